### sv/rv_enc_pkg.sv
// Package for the RV32IM encoder: format kinds, opcodes, field widths and the mnemonic table.
package rv_enc_pkg;

    // Input word layout
    localparam int CMD_W   = 6;
    localparam int REG_W   = 5;
    localparam int IMM_W   = 32;
    localparam int FSET_W  = 4;
    localparam int IN_W    = 3 * REG_W + IMM_W + 2 * FSET_W;  // 55
    localparam int IN_TD_W = ((IN_W + 7) / 8) * 8;             // 56
    localparam int WORD_W  = 32;

    // Major opcodes
    localparam logic [6:0] OP_LUI    = 7'b0110111;
    localparam logic [6:0] OP_AUIPC  = 7'b0010111;
    localparam logic [6:0] OP_JAL    = 7'b1101111;
    localparam logic [6:0] OP_JALR   = 7'b1100111;
    localparam logic [6:0] OP_BRANCH = 7'b1100011;
    localparam logic [6:0] OP_LOAD   = 7'b0000011;
    localparam logic [6:0] OP_STORE  = 7'b0100011;
    localparam logic [6:0] OP_IMM    = 7'b0010011;
    localparam logic [6:0] OP_REG    = 7'b0110011;
    localparam logic [6:0] OP_SYSTEM = 7'b1110011;
    localparam logic [6:0] OP_FENCE  = 7'b0001111;
    localparam logic [6:0] F7_NONE   = 7'b0000000;
    localparam logic [6:0] F7_ALT    = 7'b0100000;
    localparam logic [6:0] F7_MULDIV = 7'b0000001;

    // Fixed words of the fence family
    localparam logic [3:0] TSO_FM   = 4'b1000;
    localparam logic [3:0] TSO_SET  = 4'b0011;
    localparam logic [3:0] PAUSE_PR = 4'b0001;

    // Mnemonic indexes carried on tuser; codes past M_PAUSE are illegal
    typedef enum logic [CMD_W-1:0] {
        M_LUI, M_AUIPC, M_JAL, M_JALR,
        M_BEQ, M_BNE, M_BLT, M_BGE, M_BLTU, M_BGEU,
        M_LB, M_LH, M_LW, M_LBU, M_LHU,
        M_SB, M_SH, M_SW,
        M_ADDI, M_SLTI, M_SLTIU, M_XORI, M_ORI, M_ANDI,
        M_SLLI, M_SRLI, M_SRAI,
        M_ADD, M_SUB, M_SLL, M_SLT, M_SLTU, M_XOR, M_SRL, M_SRA, M_OR, M_AND,
        M_ECALL, M_EBREAK,
        M_MUL, M_MULH, M_MULHSU, M_MULHU, M_DIV, M_DIVU, M_REM, M_REMU,
        M_FENCE, M_FENCE_TSO, M_PAUSE
    } t_mnem;

    typedef enum logic [3:0] {
        K_R, K_I, K_S, K_B, K_U, K_J, K_SHIFT, K_ECALL, K_EBREAK,
        K_FENCE, K_FENCE_TSO, K_PAUSE, K_NONE
    } t_fmt;

    typedef struct packed {
        t_fmt       kind;
        logic [6:0] opcode;
        logic [2:0] f3;
        logic [6:0] f7;
    } t_enc;

    function automatic t_enc mk(t_fmt k, logic [6:0] op, logic [2:0] f3, logic [6:0] f7);
        t_enc e;
        e.kind   = k;
        e.opcode = op;
        e.f3     = f3;
        e.f7     = f7;
        return e;
    endfunction

    // Mnemonic index to format, opcode, funct3, funct7
    function automatic t_enc enc_lookup(logic [CMD_W-1:0] cmd);
        t_enc e;
        case (cmd)
            M_LUI:       e = mk(K_U,     OP_LUI,    3'd0, F7_NONE);
            M_AUIPC:     e = mk(K_U,     OP_AUIPC,  3'd0, F7_NONE);
            M_JAL:       e = mk(K_J,     OP_JAL,    3'd0, F7_NONE);
            M_JALR:      e = mk(K_I,     OP_JALR,   3'd0, F7_NONE);
            M_BEQ:       e = mk(K_B,     OP_BRANCH, 3'd0, F7_NONE);
            M_BNE:       e = mk(K_B,     OP_BRANCH, 3'd1, F7_NONE);
            M_BLT:       e = mk(K_B,     OP_BRANCH, 3'd4, F7_NONE);
            M_BGE:       e = mk(K_B,     OP_BRANCH, 3'd5, F7_NONE);
            M_BLTU:      e = mk(K_B,     OP_BRANCH, 3'd6, F7_NONE);
            M_BGEU:      e = mk(K_B,     OP_BRANCH, 3'd7, F7_NONE);
            M_LB:        e = mk(K_I,     OP_LOAD,   3'd0, F7_NONE);
            M_LH:        e = mk(K_I,     OP_LOAD,   3'd1, F7_NONE);
            M_LW:        e = mk(K_I,     OP_LOAD,   3'd2, F7_NONE);
            M_LBU:       e = mk(K_I,     OP_LOAD,   3'd4, F7_NONE);
            M_LHU:       e = mk(K_I,     OP_LOAD,   3'd5, F7_NONE);
            M_SB:        e = mk(K_S,     OP_STORE,  3'd0, F7_NONE);
            M_SH:        e = mk(K_S,     OP_STORE,  3'd1, F7_NONE);
            M_SW:        e = mk(K_S,     OP_STORE,  3'd2, F7_NONE);
            M_ADDI:      e = mk(K_I,     OP_IMM,    3'd0, F7_NONE);
            M_SLTI:      e = mk(K_I,     OP_IMM,    3'd2, F7_NONE);
            M_SLTIU:     e = mk(K_I,     OP_IMM,    3'd3, F7_NONE);
            M_XORI:      e = mk(K_I,     OP_IMM,    3'd4, F7_NONE);
            M_ORI:       e = mk(K_I,     OP_IMM,    3'd6, F7_NONE);
            M_ANDI:      e = mk(K_I,     OP_IMM,    3'd7, F7_NONE);
            M_SLLI:      e = mk(K_SHIFT, OP_IMM,    3'd1, F7_NONE);
            M_SRLI:      e = mk(K_SHIFT, OP_IMM,    3'd5, F7_NONE);
            M_SRAI:      e = mk(K_SHIFT, OP_IMM,    3'd5, F7_ALT);
            M_ADD:       e = mk(K_R,     OP_REG,    3'd0, F7_NONE);
            M_SUB:       e = mk(K_R,     OP_REG,    3'd0, F7_ALT);
            M_SLL:       e = mk(K_R,     OP_REG,    3'd1, F7_NONE);
            M_SLT:       e = mk(K_R,     OP_REG,    3'd2, F7_NONE);
            M_SLTU:      e = mk(K_R,     OP_REG,    3'd3, F7_NONE);
            M_XOR:       e = mk(K_R,     OP_REG,    3'd4, F7_NONE);
            M_SRL:       e = mk(K_R,     OP_REG,    3'd5, F7_NONE);
            M_SRA:       e = mk(K_R,     OP_REG,    3'd5, F7_ALT);
            M_OR:        e = mk(K_R,     OP_REG,    3'd6, F7_NONE);
            M_AND:       e = mk(K_R,     OP_REG,    3'd7, F7_NONE);
            M_ECALL:     e = mk(K_ECALL, OP_SYSTEM, 3'd0, F7_NONE);
            M_EBREAK:    e = mk(K_EBREAK, OP_SYSTEM, 3'd0, F7_NONE);
            M_MUL:       e = mk(K_R,     OP_REG,    3'd0, F7_MULDIV);
            M_MULH:      e = mk(K_R,     OP_REG,    3'd1, F7_MULDIV);
            M_MULHSU:    e = mk(K_R,     OP_REG,    3'd2, F7_MULDIV);
            M_MULHU:     e = mk(K_R,     OP_REG,    3'd3, F7_MULDIV);
            M_DIV:       e = mk(K_R,     OP_REG,    3'd4, F7_MULDIV);
            M_DIVU:      e = mk(K_R,     OP_REG,    3'd5, F7_MULDIV);
            M_REM:       e = mk(K_R,     OP_REG,    3'd6, F7_MULDIV);
            M_REMU:      e = mk(K_R,     OP_REG,    3'd7, F7_MULDIV);
            M_FENCE:     e = mk(K_FENCE, OP_FENCE,  3'd0, F7_NONE);
            M_FENCE_TSO: e = mk(K_FENCE_TSO, OP_FENCE, 3'd0, F7_NONE);
            M_PAUSE:     e = mk(K_PAUSE, OP_FENCE,  3'd0, F7_NONE);
            default:     e = mk(K_NONE,  7'd0,      3'd0, F7_NONE);
        endcase
        return e;
    endfunction

endpackage

### sv/rv32im_instruction_encoder_core.sv
// RV32IM instruction encoder: registered input, table lookup and format packing, result register.
//
//  channel  | dir | tdata (lsb up)                                 | tuser
//  s_axis   | in  | rd[4:0] rs1[9:5] rs2[14:10] imm[46:15]          | cmd[5:0]
//           |     | fence_pred[50:47] fence_succ[54:51] zero[55]    |
//  m_axis   | out | instr_word[31:0]                               | -
//
//  One word per cycle sustained while m_axis_tready is high; data passes the input register, then the result register.
//  The lookup and packing between the two registers is a single table read and a mux.
//  Reset (i_rst_n low, synchronous) clears only the two stage valid bits.
//  When m_axis_tready is low the result holds and the input register still fills once,
//  so s_axis_tready drops only when both stages are occupied.
module rv32im_instruction_encoder_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // rd, rs1, rs2, imm, fence_pred, fence_succ, zero pad (lowest bit up)
    input  logic [rv_enc_pkg::IN_TD_W-1:0]    s_axis_tdata,
    // cmd
    input  logic [rv_enc_pkg::CMD_W-1:0]      s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // instr_word
    output logic [rv_enc_pkg::WORD_W-1:0]     m_axis_tdata
);
    import rv_enc_pkg::*;

    // Input stage
    logic                r_in_vld;
    logic [CMD_W-1:0]    r_cmd;
    logic [REG_W-1:0]    r_rd, r_rs1, r_rs2;
    logic [IMM_W-1:0]    r_imm;
    logic [FSET_W-1:0]   r_pred, r_succ;

    // Result stage
    logic                r_out_vld;
    logic [WORD_W-1:0]   r_word;
    logic [WORD_W-1:0]   n_word;

    logic in_acc, in_adv;
    t_enc enc;

    assign in_adv        = !r_out_vld || m_axis_tready;
    assign s_axis_tready = !r_in_vld || in_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
        if (in_acc) begin
            r_cmd  <= s_axis_tuser;
            r_rd   <= s_axis_tdata[4:0];
            r_rs1  <= s_axis_tdata[9:5];
            r_rs2  <= s_axis_tdata[14:10];
            r_imm  <= s_axis_tdata[46:15];
            r_pred <= s_axis_tdata[50:47];
            r_succ <= s_axis_tdata[54:51];
        end
    end

    // Lookup and format packing
    always_comb begin
        enc = enc_lookup(r_cmd);
        case (enc.kind)
            K_R:     n_word = {enc.f7, r_rs2, r_rs1, enc.f3, r_rd, enc.opcode};
            K_I:     n_word = {r_imm[11:0], r_rs1, enc.f3, r_rd, enc.opcode};
            K_SHIFT: n_word = {enc.f7, r_imm[4:0], r_rs1, enc.f3, r_rd, enc.opcode};
            K_S:     n_word = {r_imm[11:5], r_rs2, r_rs1, enc.f3, r_imm[4:0], enc.opcode};
            K_B:     n_word = {r_imm[12], r_imm[10:5], r_rs2, r_rs1, enc.f3,
                               r_imm[4:1], r_imm[11], enc.opcode};
            K_U:     n_word = {r_imm[19:0], r_rd, enc.opcode};
            K_J:     n_word = {r_imm[20], r_imm[10:1], r_imm[11], r_imm[19:12],
                               r_rd, enc.opcode};
            K_ECALL:     n_word = {25'd0, enc.opcode};
            K_EBREAK:    n_word = {11'd0, 1'b1, 13'd0, enc.opcode};
            K_FENCE:     n_word = {4'd0, r_pred, r_succ, 13'd0, enc.opcode};
            K_FENCE_TSO: n_word = {TSO_FM, TSO_SET, TSO_SET, 13'd0, enc.opcode};
            K_PAUSE:     n_word = {4'd0, PAUSE_PR, 4'd0, 13'd0, enc.opcode};
            default:     n_word = '0;
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (in_adv) begin
            r_out_vld <= r_in_vld;
        end
        if (in_adv && r_in_vld) begin
            r_word <= n_word;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_word;

`ifndef ASSERT_OFF
    // An accepted word always lands in the input stage
    a_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_in_vld)
        else $error("accepted word not held in input stage");

    // A word moving out of the input stage appears at the result
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && in_adv) |=> r_out_vld)
        else $error("word lost between stages");

    // A blocked input stage keeps its word
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !in_adv) |=> (r_in_vld && $stable(r_cmd) && $stable(r_imm)))
        else $error("input stage changed while blocked");

    // Every nonzero result carries a 32-bit opcode (low bits 11)
    a_opcode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_word != 32'd0)) |-> (r_word[1:0] == 2'b11))
        else $error("result word has a bad opcode");
`endif

endmodule

### test/tb_rv32im_instruction_encoder_core.sv
// Testbench for the RV32IM encoder core: random and directed instructions checked against a predictor.
`timescale 1ns / 100ps

module tb_rv32im_instruction_encoder_core;
    import rv_enc_pkg::*;

    // Bit layouts of the encoded word
    typedef enum logic [3:0] {
        L_R, L_I, L_S, L_B, L_U, L_J, L_SHIFT, L_ECALL, L_EBREAK,
        L_FENCE, L_TSO, L_PAUSE, L_ILLEGAL
    } t_layout;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [REG_W-1:0]  rd;
        logic [REG_W-1:0]  rs1;
        logic [REG_W-1:0]  rs2;
        logic [IMM_W-1:0]  imm;
        logic [FSET_W-1:0] pred;
        logic [FSET_W-1:0] succ;
    } t_instr;

    localparam logic [CMD_W-1:0] CMD_FIRST_BAD = CMD_W'(M_PAUSE) + 1'b1;
    localparam logic [CMD_W-1:0] CMD_LAST_BAD  = '1;
    localparam int N_DIRECTED   = 27;
    localparam int N_RANDOM     = 1700;
    localparam int LIMIT_CYCLES = 100000;
    localparam int DRAIN_CYCLES = 10;
    localparam int STALL_LEN    = 120;
    localparam int STALL_AT     = 300;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TD_W-1:0]     s_axis_tdata = '0;
    logic [CMD_W-1:0]       s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [WORD_W-1:0]      m_axis_tdata;

    t_instr                 instr_queue[$];
    t_instr                 cur_instr;
    logic [WORD_W-1:0]      expected_words[$];
    logic                   word_taken = 1'b0;
    int                     words_in = 0;
    int                     words_out = 0;
    int                     mismatch_cnt = 0;
    int                     cycle_cnt = 0;
    int                     stall_left = 0;
    logic                   stall_done = 1'b0;
    logic [CMD_W-1:0]       directed_cmds [N_DIRECTED];

    rv32im_instruction_encoder_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Predicted machine word for one instruction
    function automatic logic [WORD_W-1:0] encode_word(t_instr it);
        t_layout     lay;
        logic [6:0]  op;
        logic [6:0]  f7;
        logic [2:0]  f3;
        logic [31:0] im;
        logic [31:0] w;
        lay = L_ILLEGAL;
        op  = '0;
        f7  = F7_NONE;
        f3  = 3'd0;
        im  = it.imm;
        // layout and major opcode
        case (it.cmd)
            M_LUI:       begin lay = L_U; op = OP_LUI; end
            M_AUIPC:     begin lay = L_U; op = OP_AUIPC; end
            M_JAL:       begin lay = L_J; op = OP_JAL; end
            M_JALR:      begin lay = L_I; op = OP_JALR; end
            M_BEQ, M_BNE, M_BLT, M_BGE, M_BLTU, M_BGEU: begin
                lay = L_B; op = OP_BRANCH;
            end
            M_LB, M_LH, M_LW, M_LBU, M_LHU: begin
                lay = L_I; op = OP_LOAD;
            end
            M_SB, M_SH, M_SW: begin
                lay = L_S; op = OP_STORE;
            end
            M_ADDI, M_SLTI, M_SLTIU, M_XORI, M_ORI, M_ANDI: begin
                lay = L_I; op = OP_IMM;
            end
            M_SLLI, M_SRLI, M_SRAI: begin
                lay = L_SHIFT; op = OP_IMM;
            end
            M_ADD, M_SUB, M_SLL, M_SLT, M_SLTU, M_XOR, M_SRL, M_SRA, M_OR, M_AND,
            M_MUL, M_MULH, M_MULHSU, M_MULHU, M_DIV, M_DIVU, M_REM, M_REMU: begin
                lay = L_R; op = OP_REG;
            end
            M_ECALL:     lay = L_ECALL;
            M_EBREAK:    lay = L_EBREAK;
            M_FENCE:     lay = L_FENCE;
            M_FENCE_TSO: lay = L_TSO;
            M_PAUSE:     lay = L_PAUSE;
            default:     lay = L_ILLEGAL;
        endcase
        // funct3, grouped by value
        case (it.cmd)
            M_BNE, M_LH, M_SH, M_SLLI, M_SLL, M_MULH:                f3 = 3'd1;
            M_LW, M_SW, M_SLTI, M_SLT, M_MULHSU:                     f3 = 3'd2;
            M_SLTIU, M_SLTU, M_MULHU:                                f3 = 3'd3;
            M_BLT, M_LBU, M_XORI, M_XOR, M_DIV:                      f3 = 3'd4;
            M_BGE, M_LHU, M_SRLI, M_SRAI, M_SRL, M_SRA, M_DIVU:      f3 = 3'd5;
            M_BLTU, M_ORI, M_OR, M_REM:                              f3 = 3'd6;
            M_BGEU, M_ANDI, M_AND, M_REMU:                           f3 = 3'd7;
            default:                                                 f3 = 3'd0;
        endcase
        // funct7
        case (it.cmd)
            M_SRAI, M_SUB, M_SRA: f7 = F7_ALT;
            M_MUL, M_MULH, M_MULHSU, M_MULHU, M_DIV, M_DIVU, M_REM, M_REMU:
                f7 = F7_MULDIV;
            default: f7 = F7_NONE;
        endcase
        // pack; immediate bits beyond the layout are dropped
        case (lay)
            L_R:      w = {f7, it.rs2, it.rs1, f3, it.rd, op};
            L_I:      w = {im[11:0], it.rs1, f3, it.rd, op};
            L_SHIFT:  w = {f7, im[4:0], it.rs1, f3, it.rd, op};
            L_S:      w = {im[11:5], it.rs2, it.rs1, f3, im[4:0], op};
            L_B:      w = {im[12], im[10:5], it.rs2, it.rs1, f3, im[4:1], im[11], op};
            L_U:      w = {im[19:0], it.rd, op};
            L_J:      w = {im[20], im[10:1], im[11], im[19:12], it.rd, op};
            L_ECALL:  w = {25'd0, OP_SYSTEM};
            L_EBREAK: w = {12'd1, 13'd0, OP_SYSTEM};
            L_FENCE:  w = {4'd0, it.pred, it.succ, 13'd0, OP_FENCE};
            L_TSO:    w = {TSO_FM, TSO_SET, TSO_SET, 13'd0, OP_FENCE};
            L_PAUSE:  w = {4'd0, PAUSE_PR, 4'd0, 13'd0, OP_FENCE};
            default:  w = '0;
        endcase
        return w;
    endfunction

    // Random instruction; immediates lean toward small values and bit patterns around powers of two
    function automatic t_instr random_instr();
        t_instr it;
        int     sh;
        if ($urandom_range(0, 99) < 6)
            it.cmd = CMD_W'($urandom_range(CMD_FIRST_BAD, CMD_LAST_BAD));
        else
            it.cmd = CMD_W'($urandom_range(0, M_PAUSE));
        it.rd   = REG_W'($urandom_range(0, 31));
        it.rs1  = REG_W'($urandom_range(0, 31));
        it.rs2  = REG_W'($urandom_range(0, 31));
        it.pred = FSET_W'($urandom_range(0, 15));
        it.succ = FSET_W'($urandom_range(0, 15));
        case ($urandom_range(0, 3))
            1: it.imm = 32'($urandom_range(0, 8191)) - 32'd4096;
            2: begin
                sh = $urandom_range(0, 31);
                it.imm = 32'd1 << sh;
                if ($urandom_range(0, 1) != 0)
                    it.imm = it.imm - 32'd1;
                if ($urandom_range(0, 1) != 0)
                    it.imm = ~it.imm;
            end
            default: it.imm = $urandom;
        endcase
        return it;
    endfunction

    // Stimulus list, reset and end of run
    initial begin
        t_instr it;
        directed_cmds = '{M_LUI, M_AUIPC, M_JAL, M_JALR, M_BEQ, M_BGEU, M_LB, M_LHU,
                          M_SB, M_SW, M_ADDI, M_ANDI, M_SLLI, M_SRLI, M_SRAI, M_ADD,
                          M_SUB, M_AND, M_ECALL, M_EBREAK, M_MUL, M_REMU, M_FENCE,
                          M_FENCE_TSO, M_PAUSE, CMD_FIRST_BAD, CMD_LAST_BAD};
        // field extremes rotate across the directed words
        for (int i = 0; i < N_DIRECTED; i++) begin
            it.cmd  = directed_cmds[i];
            it.rd   = (i % 2 == 0) ? '1 : '0;
            it.rs1  = (i % 3 == 0) ? '1 : '0;
            it.rs2  = (i % 2 == 1) ? '1 : '0;
            it.pred = (i % 2 == 0) ? '1 : '0;
            it.succ = (i % 3 == 1) ? '1 : '0;
            case (i % 4)
                0: it.imm = 32'h7FFF_FFFF;
                1: it.imm = 32'h8000_0000;
                2: it.imm = 32'hFFFF_FFFF;
                default: it.imm = 32'h0000_0000;
            endcase
            instr_queue.push_back(it);
        end
        for (int i = 0; i < N_RANDOM; i++)
            instr_queue.push_back(random_instr());

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (instr_queue.size() != 0 || s_axis_tvalid || expected_words.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_words.size() == 0)
            $display("tb_rv32im_instruction_encoder_core passed");
        else
            $display("tb_rv32im_instruction_encoder_core failed");
        $finish;
    end

    // Input driver: next word after a handshake, random gaps except in the quiet run
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!s_axis_tvalid || word_taken) begin
                if (instr_queue.size() != 0 &&
                    ((words_in >= 800 && words_in < 1100) || $urandom_range(0, 99) >= 10)) begin
                    cur_instr = instr_queue.pop_front();
                    s_axis_tdata  <= {1'b0, cur_instr.succ, cur_instr.pred, cur_instr.imm,
                                      cur_instr.rs2, cur_instr.rs1, cur_instr.rd};
                    s_axis_tuser  <= cur_instr.cmd;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long output hold-off, counted here so the input side keeps pushing
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (!stall_done && words_out >= STALL_AT) begin
            stall_left <= STALL_LEN;
            stall_done <= 1'b1;
        end
    end

    // Output ready: random back-pressure, none in the quiet run, held low during the hold-off
    always @(negedge i_clk) begin
        if (i_rst_n)
            m_axis_tready <= (stall_left == 0) &&
                             ((words_out >= 800 && words_out < 1100) ||
                              $urandom_range(0, 99) >= 10);
    end

    // Monitor: check output words in order, then log accepted input words
    always @(posedge i_clk) begin
        logic [WORD_W-1:0] exp_word;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            words_out <= words_out + 1;
            if (expected_words.size() == 0) begin
                if (mismatch_cnt < 10)
                    $display("unexpected word %h at output word %0d", m_axis_tdata, words_out);
                mismatch_cnt <= mismatch_cnt + 1;
            end else begin
                exp_word = expected_words.pop_front();
                if (m_axis_tdata !== exp_word) begin
                    if (mismatch_cnt < 10)
                        $display("word %0d: expected %h, got %h",
                                 words_out, exp_word, m_axis_tdata);
                    mismatch_cnt <= mismatch_cnt + 1;
                end
            end
        end
        word_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            expected_words.push_back(encode_word(cur_instr));
            words_in <= words_in + 1;
        end
    end

    // Timeout
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("tb_rv32im_instruction_encoder_core failed");
            $finish;
        end
    end

endmodule
